// ----- rtl/lpht_pkg.sv -----
package lpht_pkg;

    // Table geometry. The home slot is the low bits of the key, so the slot
    // count is a power of two.
    localparam int TableSlots = 256;
    localparam int IdxW       = $clog2(TableSlots);
    localparam int CntW       = IdxW + 1;

    // Field widths.
    localparam int OpW     = 2;
    localparam int KeyW    = 31;
    localparam int HandleW = 32;
    localparam int StatusW = 2;
    localparam int SlotW   = 8;
    localparam int EntryW  = KeyW + HandleW;

    // Operation codes.
    localparam logic [OpW-1:0] OpInsert = 2'd0;
    localparam logic [OpW-1:0] OpLookup = 2'd1;
    localparam logic [OpW-1:0] OpDelete = 2'd2;

    // Status codes.
    localparam logic [StatusW-1:0] StatusOk      = 2'd0;
    localparam logic [StatusW-1:0] StatusMissing = 2'd1;
    localparam logic [StatusW-1:0] StatusFull    = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INS_SCAN,
        ST_FIND_RD,
        ST_FIND_CMP,
        ST_DEL_NEXT,
        ST_DEL_LIFT,
        ST_DEL_PLACE,
        ST_FINISH
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_item;
        logic idx_inc;
        logic ins_write;
        logic place_write;
        logic rd_en;
        logic rd_run;
        logic del_free;
        logic lift;
        logic run_inc;
        logic res_ok;
        logic res_found;
        logic res_missing;
        logic res_full;
        logic out_load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [OpW-1:0] in_op;
        logic [OpW-1:0] item_op;
        logic           idx_end;
        logic           occ_idx;
        logic           key_match;
        logic           run_end;
        logic           occ_run;
        logic           out_free;
    } t_stat;

    function automatic logic [CntW-1:0] home_of(input logic [KeyW-1:0] key);
        home_of = CntW'(key % KeyW'(TableSlots));
    endfunction

endpackage

// ----- rtl/lpht_in_if.sv -----
interface lpht_in_if;
    logic                         valid;
    logic                         ready;
    logic [lpht_pkg::OpW-1:0]     operation;
    logic [lpht_pkg::KeyW-1:0]    key;
    logic [lpht_pkg::HandleW-1:0] record_handle;

    modport source (output valid, output operation, output key, output record_handle,
                    input ready);
    modport sink (input valid, input operation, input key, input record_handle,
                  output ready);
endinterface

// ----- rtl/lpht_out_if.sv -----
interface lpht_out_if;
    logic                         valid;
    logic                         ready;
    logic [lpht_pkg::StatusW-1:0] status;
    logic [lpht_pkg::SlotW-1:0]   slot;
    logic [lpht_pkg::HandleW-1:0] found_handle;

    modport source (output valid, output status, output slot, output found_handle,
                    input ready);
    modport sink (input valid, input status, input slot, input found_handle,
                  output ready);
endinterface

// ----- rtl/lpht_ram.sv -----
module lpht_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(Depth)-1:0] i_wr_addr,
    input  logic [Width-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(Depth)-1:0] i_rd_addr,
    output logic [Width-1:0]         o_rd_data
);

    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/lpht_ctrl.sv -----
module lpht_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  lpht_pkg::t_stat i_stat,
    output lpht_pkg::t_cmd  o_cmd
);

    lpht_pkg::t_state r_state;
    lpht_pkg::t_state n_state;
    logic             w_known_op;
    logic             w_probe_stop;
    logic             w_run_stop;

    assign w_known_op   = (i_stat.in_op == lpht_pkg::OpInsert)
                       || (i_stat.in_op == lpht_pkg::OpLookup)
                       || (i_stat.in_op == lpht_pkg::OpDelete);
    assign w_probe_stop = i_stat.idx_end || !i_stat.occ_idx;
    assign w_run_stop   = i_stat.run_end || !i_stat.occ_run;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lpht_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            lpht_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_stat.in_op == lpht_pkg::OpInsert) begin
                        n_state = lpht_pkg::ST_INS_SCAN;
                    end else if (w_known_op) begin
                        n_state = lpht_pkg::ST_FIND_RD;
                    end else begin
                        n_state = lpht_pkg::ST_FINISH;
                    end
                end
            end
            lpht_pkg::ST_INS_SCAN: begin
                if (w_probe_stop) begin
                    n_state = lpht_pkg::ST_FINISH;
                end
            end
            lpht_pkg::ST_FIND_RD: begin
                if (w_probe_stop) begin
                    n_state = lpht_pkg::ST_FINISH;
                end else begin
                    n_state = lpht_pkg::ST_FIND_CMP;
                end
            end
            lpht_pkg::ST_FIND_CMP: begin
                if (!i_stat.key_match) begin
                    n_state = lpht_pkg::ST_FIND_RD;
                end else if (i_stat.item_op == lpht_pkg::OpDelete) begin
                    n_state = lpht_pkg::ST_DEL_NEXT;
                end else begin
                    n_state = lpht_pkg::ST_FINISH;
                end
            end
            lpht_pkg::ST_DEL_NEXT: begin
                if (w_run_stop) begin
                    n_state = lpht_pkg::ST_FINISH;
                end else begin
                    n_state = lpht_pkg::ST_DEL_LIFT;
                end
            end
            lpht_pkg::ST_DEL_LIFT: begin
                n_state = lpht_pkg::ST_DEL_PLACE;
            end
            lpht_pkg::ST_DEL_PLACE: begin
                // The lifted entry always fits: its own old slot is free.
                if (!i_stat.occ_idx) begin
                    n_state = lpht_pkg::ST_DEL_NEXT;
                end
            end
            lpht_pkg::ST_FINISH: begin
                if (i_stat.out_free) begin
                    n_state = lpht_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = lpht_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            lpht_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    if (!w_known_op) begin
                        o_cmd.res_missing = 1'b1;
                    end
                end
            end
            lpht_pkg::ST_INS_SCAN: begin
                if (i_stat.idx_end) begin
                    o_cmd.res_full = 1'b1;
                end else if (!i_stat.occ_idx) begin
                    o_cmd.ins_write = 1'b1;
                    o_cmd.res_ok    = 1'b1;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            lpht_pkg::ST_FIND_RD: begin
                if (w_probe_stop) begin
                    o_cmd.res_missing = 1'b1;
                end else begin
                    o_cmd.rd_en = 1'b1;
                end
            end
            lpht_pkg::ST_FIND_CMP: begin
                if (!i_stat.key_match) begin
                    o_cmd.idx_inc = 1'b1;
                end else if (i_stat.item_op == lpht_pkg::OpDelete) begin
                    o_cmd.res_ok   = 1'b1;
                    o_cmd.del_free = 1'b1;
                end else begin
                    o_cmd.res_found = 1'b1;
                end
            end
            lpht_pkg::ST_DEL_NEXT: begin
                if (!w_run_stop) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_run = 1'b1;
                end
            end
            lpht_pkg::ST_DEL_LIFT: begin
                o_cmd.lift = 1'b1;
            end
            lpht_pkg::ST_DEL_PLACE: begin
                if (!i_stat.occ_idx) begin
                    o_cmd.place_write = 1'b1;
                    o_cmd.run_inc     = 1'b1;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            lpht_pkg::ST_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                end
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// ----- rtl/lpht_dp.sv -----
module lpht_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  lpht_pkg::t_cmd               i_cmd,
    output lpht_pkg::t_stat              o_stat,
    input  logic [lpht_pkg::OpW-1:0]     i_operation,
    input  logic [lpht_pkg::KeyW-1:0]    i_key,
    input  logic [lpht_pkg::HandleW-1:0] i_record_handle,
    input  logic                         i_out_ready,
    output logic                         o_out_valid,
    output logic [lpht_pkg::StatusW-1:0] o_status,
    output logic [lpht_pkg::SlotW-1:0]   o_slot,
    output logic [lpht_pkg::HandleW-1:0] o_found_handle
);

    // Latched item.
    logic [lpht_pkg::OpW-1:0]     r_op;
    logic [lpht_pkg::KeyW-1:0]    r_key;
    logic [lpht_pkg::HandleW-1:0] r_handle;

    // Probe index and the index walking the run to the right of a freed slot.
    logic [lpht_pkg::CntW-1:0]    r_idx;
    logic [lpht_pkg::CntW-1:0]    r_run;
    logic [lpht_pkg::IdxW-1:0]    w_idx_lo;
    logic [lpht_pkg::IdxW-1:0]    w_run_lo;

    // Entry being moved during a delete.
    logic [lpht_pkg::KeyW-1:0]    r_lift_key;
    logic [lpht_pkg::HandleW-1:0] r_lift_handle;

    logic [lpht_pkg::TableSlots-1:0] r_occ;
    logic [lpht_pkg::TableSlots-1:0] n_occ;

    logic [lpht_pkg::StatusW-1:0] r_res_status;
    logic [lpht_pkg::SlotW-1:0]   r_res_slot;
    logic [lpht_pkg::HandleW-1:0] r_res_handle;

    logic                         r_out_valid;
    logic [lpht_pkg::StatusW-1:0] r_out_status;
    logic [lpht_pkg::SlotW-1:0]   r_out_slot;
    logic [lpht_pkg::HandleW-1:0] r_out_handle;

    logic                         w_wr_en;
    logic [lpht_pkg::EntryW-1:0]  w_wr_data;
    logic [lpht_pkg::IdxW-1:0]    w_rd_addr;
    logic [lpht_pkg::EntryW-1:0]  w_rd_data;
    logic [lpht_pkg::KeyW-1:0]    w_rd_key;
    logic [lpht_pkg::HandleW-1:0] w_rd_handle;

    assign w_idx_lo    = r_idx[lpht_pkg::IdxW-1:0];
    assign w_run_lo    = r_run[lpht_pkg::IdxW-1:0];
    assign w_rd_key    = w_rd_data[lpht_pkg::EntryW-1 -: lpht_pkg::KeyW];
    assign w_rd_handle = w_rd_data[lpht_pkg::HandleW-1:0];

    // Key and handle store; slots are written at the probe index only.
    assign w_wr_en   = i_cmd.ins_write || i_cmd.place_write;
    assign w_wr_data = i_cmd.ins_write ? {r_key, r_handle} : {r_lift_key, r_lift_handle};
    assign w_rd_addr = i_cmd.rd_run ? w_run_lo : w_idx_lo;

    lpht_ram #(
        .Width (lpht_pkg::EntryW),
        .Depth (lpht_pkg::TableSlots)
    ) u_entry_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_idx_lo),
        .i_wr_data (w_wr_data),
        .i_rd_en   (i_cmd.rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    always_comb begin
        n_occ = r_occ;
        if (w_wr_en) begin
            n_occ[w_idx_lo] = 1'b1;
        end
        if (i_cmd.del_free) begin
            n_occ[w_idx_lo] = 1'b0;
        end
        if (i_cmd.lift) begin
            n_occ[w_run_lo] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ       <= '0;
            r_idx       <= '0;
            r_run       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_occ <= n_occ;

            if (i_cmd.load_item) begin
                r_idx <= lpht_pkg::home_of(i_key);
            end else if (i_cmd.lift) begin
                r_idx <= lpht_pkg::home_of(w_rd_key);
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + 1'b1;
            end

            if (i_cmd.del_free) begin
                r_run <= r_idx + 1'b1;
            end else if (i_cmd.run_inc) begin
                r_run <= r_run + 1'b1;
            end

            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_op     <= i_operation;
            r_key    <= i_key;
            r_handle <= i_record_handle;
        end
        if (i_cmd.lift) begin
            r_lift_key    <= w_rd_key;
            r_lift_handle <= w_rd_handle;
        end

        if (i_cmd.res_ok) begin
            r_res_status <= lpht_pkg::StatusOk;
            r_res_slot   <= lpht_pkg::SlotW'(r_idx);
            r_res_handle <= '0;
        end else if (i_cmd.res_found) begin
            r_res_status <= lpht_pkg::StatusOk;
            r_res_slot   <= lpht_pkg::SlotW'(r_idx);
            r_res_handle <= w_rd_handle;
        end else if (i_cmd.res_missing) begin
            r_res_status <= lpht_pkg::StatusMissing;
            r_res_slot   <= '0;
            r_res_handle <= '0;
        end else if (i_cmd.res_full) begin
            r_res_status <= lpht_pkg::StatusFull;
            r_res_slot   <= '0;
            r_res_handle <= '0;
        end

        if (i_cmd.out_load) begin
            r_out_status <= r_res_status;
            r_out_slot   <= r_res_slot;
            r_out_handle <= r_res_handle;
        end
    end

    assign o_stat.in_op     = i_operation;
    assign o_stat.item_op   = r_op;
    assign o_stat.idx_end   = (r_idx == lpht_pkg::CntW'(lpht_pkg::TableSlots));
    assign o_stat.occ_idx   = r_occ[w_idx_lo];
    assign o_stat.key_match = (w_rd_key == r_key);
    assign o_stat.run_end   = (r_run == lpht_pkg::CntW'(lpht_pkg::TableSlots));
    assign o_stat.occ_run   = r_occ[w_run_lo];
    assign o_stat.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_slot         = r_out_slot;
    assign o_found_handle = r_out_handle;

endmodule

// ----- rtl/linear_probe_hash_table_unit.sv -----
// Open-addressing hash table of 256 slots with linear probing toward higher
// slots only (no wraparound). Each beat on the input carries one operation
// (insert, lookup, delete) and produces exactly one result beat. Occupancy
// lives in flip-flops cleared by reset, so the table is usable as soon as
// reset is released; keys and handles sit in one single-port-write,
// registered-read RAM. One operation is in flight at a time, and the cost is
// set by probing slot by slot: insert steps over occupied slots from home
// until it finds a free one or passes the last slot; lookup reads and
// compares one entry per probe and stops at a match, an empty slot or the
// end of the table; a delete that misses costs the same as a lookup miss,
// and one that hits costs a lookup hit plus, for each entry in the occupied
// run right of the freed slot, a read, a lift and a re-insert probe from
// its home, plus one final check. A result waiting in the output register
// does not block the next item from being accepted.
module linear_probe_hash_table_unit (
    input logic        i_clk,
    input logic        i_rst_n,
    lpht_in_if.sink    i_in,
    lpht_out_if.source o_out
);

    lpht_pkg::t_cmd  w_cmd;
    lpht_pkg::t_stat w_stat;
    logic            w_in_ready;
    logic            w_out_valid;

    logic [lpht_pkg::StatusW-1:0] w_status;
    logic [lpht_pkg::SlotW-1:0]   w_slot;
    logic [lpht_pkg::HandleW-1:0] w_found_handle;

    lpht_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    lpht_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_operation     (i_in.operation),
        .i_key           (i_in.key),
        .i_record_handle (i_in.record_handle),
        .i_out_ready     (o_out.ready),
        .o_out_valid     (w_out_valid),
        .o_status        (w_status),
        .o_slot          (w_slot),
        .o_found_handle  (w_found_handle)
    );

    assign i_in.ready         = w_in_ready;
    assign o_out.valid        = w_out_valid;
    assign o_out.status       = w_status;
    assign o_out.slot         = w_slot;
    assign o_out.found_handle = w_found_handle;

endmodule

// ----- verif/tb_linear_probe_hash_table_unit.sv -----
`timescale 1ns / 100ps

module tb_linear_probe_hash_table_unit;
    import lpht_pkg::*;

    // The spare code is not in the package; the block returns a missing status.
    localparam logic [OpW-1:0] OpSpare = 2'd3;

    localparam int ResetCycles  = 9;
    localparam int RandomItems  = 1100;
    localparam int HoldAtItem   = 300;
    localparam int LongHold     = 400;
    localparam int DrainCycles  = 300;
    localparam int CycleLimit   = 12_000_000;
    localparam int OccupancyCap = 56;
    localparam int KnownIdCap   = 128;
    localparam bit Pinned       = 1'b1;
    localparam bit Predicted    = 1'b0;

    typedef struct packed {
        logic [OpW-1:0]     op;
        logic [KeyW-1:0]    key;
        logic [HandleW-1:0] handle;
    } table_op_t;

    typedef struct packed {
        logic [StatusW-1:0] status;
        logic [SlotW-1:0]   slot;
        logic [HandleW-1:0] found_handle;
    } table_reply_t;

    typedef struct packed {
        table_op_t    cmd;
        bit           pin;
        table_reply_t reply;
    } step_row_t;

    typedef enum {SinkOpen, SinkEveryFourth, SinkCoinFlip, SinkBursty} sink_mode_t;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    lpht_in_if  in_if ();
    lpht_out_if out_if ();

    linear_probe_hash_table_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // Shadow copy of the table, updated as each beat is accepted.
    bit                 slot_taken   [TableSlots];
    logic [KeyW-1:0]    slot_id      [TableSlots];
    logic [HandleW-1:0] slot_payload [TableSlots];

    table_reply_t       pending_replies [$];
    logic [KeyW-1:0]    known_ids [$];
    int                 mismatch_count = 0;
    int                 burst_left     = 0;
    bit                 hold_request   = 1'b0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic step_row_t mk_row(input logic [OpW-1:0] op,
                                         input logic [KeyW-1:0] key,
                                         input logic [HandleW-1:0] handle,
                                         input bit pin = Predicted,
                                         input logic [StatusW-1:0] status = StatusOk,
                                         input logic [SlotW-1:0] slot = '0,
                                         input logic [HandleW-1:0] found = '0);
        step_row_t row;
        row.cmd.op             = op;
        row.cmd.key            = key;
        row.cmd.handle         = handle;
        row.pin                = pin;
        row.reply.status       = status;
        row.reply.slot         = slot;
        row.reply.found_handle = found;
        return row;
    endfunction

    // First free slot from home upward; no wraparound past the last slot.
    function automatic bit place_entry(input logic [KeyW-1:0] id,
                                       input logic [HandleW-1:0] payload,
                                       output int where);
        where = 0;
        for (int s = int'(id % TableSlots); s < TableSlots; s++) begin
            if (!slot_taken[s]) begin
                slot_taken[s]   = 1'b1;
                slot_id[s]      = id;
                slot_payload[s] = payload;
                where           = s;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // First matching entry from home; an empty slot ends the search.
    function automatic bit find_entry(input logic [KeyW-1:0] id, output int where);
        where = 0;
        for (int s = int'(id % TableSlots); s < TableSlots; s++) begin
            if (!slot_taken[s]) begin
                return 1'b0;
            end
            if (slot_id[s] == id) begin
                where = s;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic table_reply_t predict_reply(input table_op_t cmd);
        table_reply_t r;
        int at;
        int scratch;
        int j;
        r.status       = StatusMissing;
        r.slot         = '0;
        r.found_handle = '0;
        case (cmd.op)
            OpInsert: begin
                if (place_entry(cmd.key, cmd.handle, at)) begin
                    r.status = StatusOk;
                    r.slot   = SlotW'(at);
                end else begin
                    r.status = StatusFull;
                end
            end
            OpLookup: begin
                if (find_entry(cmd.key, at)) begin
                    r.status       = StatusOk;
                    r.slot         = SlotW'(at);
                    r.found_handle = slot_payload[at];
                end
            end
            OpDelete: begin
                if (find_entry(cmd.key, at)) begin
                    r.status = StatusOk;
                    r.slot   = SlotW'(at);
                    slot_taken[at] = 1'b0;
                    // Lift the occupied run to the right and place each entry again,
                    // lowest slot first.
                    j = at + 1;
                    while (j < TableSlots && slot_taken[j]) begin
                        slot_taken[j] = 1'b0;
                        void'(place_entry(slot_id[j], slot_payload[j], scratch));
                        j++;
                    end
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    task automatic offer_beat(input step_row_t row);
        table_reply_t want;
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
        burst_left--;
        @(negedge i_clk);
        if (gap > 0) begin
            in_if.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_if.operation     = row.cmd.op;
        in_if.key           = row.cmd.key;
        in_if.record_handle = row.cmd.handle;
        in_if.valid         = 1'b1;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        want = predict_reply(row.cmd);
        pending_replies.push_back(row.pin ? row.reply : want);
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin : reply_check
        table_reply_t want;
        if (i_rst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
            if (pending_replies.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %0h/%0h/%0h",
                         $time, out_if.status, out_if.slot, out_if.found_handle);
                mismatch_count++;
            end else begin
                want = pending_replies.pop_front();
                compare_field("status", 32'(want.status), 32'(out_if.status));
                compare_field("slot", 32'(want.slot), 32'(out_if.slot));
                compare_field("found_handle", want.found_handle, out_if.found_handle);
            end
        end
    end

    initial begin : result_sink
        sink_mode_t mode;
        int         phase_cycle;
        int         stall_left;
        int         hold_left;
        bit         hold_taken;
        mode        = SinkOpen;
        phase_cycle = 0;
        stall_left  = 0;
        hold_left   = 0;
        hold_taken  = 1'b0;
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left  = LongHold;
            end
            if (hold_left > 0) begin
                // Long hold-off: the output register fills and the input must stall.
                hold_left--;
                out_if.ready = 1'b0;
            end else begin
                phase_cycle++;
                if (phase_cycle % 256 == 0) begin
                    mode = sink_mode_t'($urandom_range(0, 3));
                end
                case (mode)
                    SinkOpen:        out_if.ready = 1'b1;
                    SinkEveryFourth: out_if.ready = (phase_cycle % 4) != 3;
                    SinkCoinFlip:    out_if.ready = 1'($urandom_range(0, 1));
                    default: begin
                        if (stall_left > 0) begin
                            stall_left--;
                            out_if.ready = 1'b0;
                        end else begin
                            out_if.ready = 1'b1;
                            if ($urandom_range(0, 7) == 0) begin
                                stall_left = $urandom_range(1, 12);
                            end
                        end
                    end
                endcase
            end
        end
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CycleLimit) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin : stimulus
        step_row_t                directed [$];
        table_op_t                cmd;
        logic [IdxW-1:0]          home;
        logic [KeyW-IdxW-1:0]     upper;
        int                       filled;
        int                       pick;
        bit                       reuse;
        in_if.valid         = 1'b0;
        in_if.operation     = OpInsert;
        in_if.key           = '0;
        in_if.record_handle = '0;

        directed = '{
            mk_row(OpLookup, 31'd0, 32'd0, Pinned, StatusMissing),
            mk_row(OpDelete, 31'h7FFF_FFFF, 32'd0, Pinned, StatusMissing),
            mk_row(OpSpare, 31'd5, 32'h1234_5678, Pinned, StatusMissing),
            mk_row(OpInsert, 31'd0, 32'd0, Pinned, StatusOk, 8'd0),
            mk_row(OpInsert, 31'h7FFF_FFFF, 32'hFFFF_FFFF, Pinned, StatusOk, 8'd255),
            mk_row(OpInsert, 31'd255, 32'hA5A5_A5A5, Pinned, StatusFull),
            mk_row(OpLookup, 31'h7FFF_FFFF, 32'd0, Pinned, StatusOk, 8'd255, 32'hFFFF_FFFF),
            mk_row(OpInsert, 31'd256, 32'd1, Pinned, StatusOk, 8'd1),
            mk_row(OpInsert, 31'd512, 32'd2, Pinned, StatusOk, 8'd2),
            mk_row(OpInsert, 31'd1, 32'd3, Pinned, StatusOk, 8'd3),
            mk_row(OpInsert, 31'd0, 32'd4, Pinned, StatusOk, 8'd4),
            mk_row(OpLookup, 31'd0, 32'hFFFF_FFFF, Pinned, StatusOk, 8'd0, 32'd0),
            mk_row(OpDelete, 31'd0, 32'd0, Pinned, StatusOk, 8'd0),
            mk_row(OpLookup, 31'd0, 32'd0),
            mk_row(OpLookup, 31'd1, 32'd0),
            mk_row(OpLookup, 31'h5555_5555, 32'd0, Pinned, StatusMissing),
            mk_row(OpInsert, 31'h2AAA_AAAA, 32'h5A5A_5A5A),
            mk_row(OpDelete, 31'd256, 32'd0),
            mk_row(OpLookup, 31'd512, 32'd0),
            mk_row(OpLookup, 31'd768, 32'd0),
            mk_row(OpInsert, 31'd254, 32'h1234_5678, Pinned, StatusOk, 8'd254),
            mk_row(OpInsert, 31'h7FFF_FFFE, 32'h0F0F_0F0F, Pinned, StatusFull),
            mk_row(OpDelete, 31'h7FFF_FFFF, 32'd0, Pinned, StatusOk, 8'd255),
            mk_row(OpInsert, 31'h7FFF_FFFE, 32'h0F0F_0F0F),
            mk_row(OpSpare, 31'd0, 32'hFFFF_FFFF, Pinned, StatusMissing),
            mk_row(OpLookup, 31'h7FFF_FFFE, 32'd0)
        };

        repeat (ResetCycles) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed[n]) begin
            offer_beat(directed[n]);
        end

        for (int n = 0; n < RandomItems; n++) begin
            if (n == HoldAtItem) begin
                hold_request = 1'b1;
            end
            filled = 0;
            foreach (slot_taken[s]) begin
                filled += slot_taken[s];
            end

            // Keep the table partly loaded so clusters form and deletes move runs.
            pick = $urandom_range(0, 99);
            if (pick < 4) begin
                cmd.op = OpSpare;
            end else if (pick < 46) begin
                cmd.op = (filled < OccupancyCap) ? OpInsert : OpDelete;
            end else if (pick < 72) begin
                cmd.op = OpLookup;
            end else begin
                cmd.op = OpDelete;
            end

            reuse = (cmd.op == OpInsert) ? ($urandom_range(0, 9) < 2)
                                         : ($urandom_range(0, 9) < 8);
            if (reuse && known_ids.size() > 0) begin
                cmd.key = known_ids[$urandom_range(0, known_ids.size() - 1)];
            end else begin
                // Homes crowd the top of the table, where probes run off the end.
                pick = $urandom_range(0, 9);
                if (pick < 5) begin
                    home = IdxW'(TableSlots - 16 + $urandom_range(0, 15));
                end else if (pick < 8) begin
                    home = IdxW'($urandom_range(0, 23));
                end else begin
                    home = IdxW'($urandom);
                end
                pick = $urandom_range(0, 5);
                if (pick == 0) begin
                    upper = '0;
                end else if (pick == 1) begin
                    upper = '1;
                end else begin
                    upper = (KeyW - IdxW)'($urandom);
                end
                cmd.key = {upper, home};
            end

            pick = $urandom_range(0, 7);
            if (pick == 0) begin
                cmd.handle = '0;
            end else if (pick == 1) begin
                cmd.handle = '1;
            end else begin
                cmd.handle = $urandom;
            end

            if (cmd.op == OpInsert) begin
                known_ids.push_back(cmd.key);
                if (known_ids.size() > KnownIdCap) begin
                    void'(known_ids.pop_front());
                end
            end
            offer_beat(mk_row(cmd.op, cmd.key, cmd.handle));
        end

        @(negedge i_clk);
        in_if.valid = 1'b0;

        while (pending_replies.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DrainCycles) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ----- linear_probe_hash_table_unit.f -----
rtl/lpht_pkg.sv
rtl/lpht_in_if.sv
rtl/lpht_out_if.sv
rtl/lpht_ram.sv
rtl/lpht_ctrl.sv
rtl/lpht_dp.sv
rtl/linear_probe_hash_table_unit.sv
verif/tb_linear_probe_hash_table_unit.sv
